// ===== sv/iexf_pkg.sv =====
package iexf_pkg;

    localparam int GRID_CELLS = 4096;
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int MAX_LAYERS = 16;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_EVAL  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [2:0] REG_DIM_X        = 3'd0;
    localparam logic [2:0] REG_DIM_Y        = 3'd1;
    localparam logic [2:0] REG_DIM_Z        = 3'd2;
    localparam logic [2:0] REG_FIELD_SCALE  = 3'd3;
    localparam logic [2:0] REG_ENERGY_SCALE = 3'd4;

    typedef struct packed {
        logic [6:0]         dim_x;
        logic [6:0]         dim_y;
        logic [4:0]         dim_z;
        logic signed [31:0] field_scale;
        logic signed [31:0] energy_scale;
    } cfg_t;

    // One classified transaction as handed from the front to the back.
    typedef struct packed {
        action_t            action;
        logic [ADDR_W-1:0]  own_addr;
        logic [1:0]         pvalid;
        logic [ADDR_W-1:0]  paddr_a;
        logic [ADDR_W-1:0]  paddr_b;
        logic signed [23:0] mag_x;
        logic signed [23:0] mag_y;
        logic signed [23:0] mag_z;
        logic [23:0]        sat;
        logic signed [31:0] coupling;
    } cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Division by 65536 that truncates toward zero.
    function automatic logic signed [47:0] trunc16(input logic signed [63:0] p);
        logic signed [63:0] b;
        b = p + (p[63] ? 64'sd65535 : 64'sd0);
        return b[63:16];
    endfunction

endpackage

// ===== sv/iexf_front.sv =====
module iexf_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  iexf_pkg::cfg_t            cfg,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic [5:0]                cell_x,
    input  logic [5:0]                cell_y,
    input  logic [3:0]                cell_z,
    input  logic signed [23:0]        mag_x,
    input  logic signed [23:0]        mag_y,
    input  logic signed [23:0]        mag_z,
    input  logic [23:0]               sat_mag,
    input  logic signed [4:0]         layer_a,
    input  logic signed [4:0]         layer_b,
    input  logic signed [31:0]        coupling,
    output iexf_pkg::cmd_t            head,
    output logic                      head_valid,
    input  logic                      pop
);
    import iexf_pkg::*;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    cmd_t        cmd;
    logic [ADDR_W-1:0] plane;

    function automatic logic [ADDR_W-1:0] addr_of(
        input logic [5:0] x, input logic [5:0] y, input logic [3:0] z,
        input logic [6:0] dx, input logic [ADDR_W-1:0] pl);
        logic [ADDR_W-1:0] zt;
        logic [ADDR_W-1:0] yt;
        zt = ADDR_W'(z * pl);
        yt = ADDR_W'(y * dx);
        return zt + yt + ADDR_W'(x);
    endfunction

    function automatic logic partner_ok(input logic signed [4:0] l,
                                        input logic [3:0] z, input logic [4:0] dz);
        return !l[4] && (l[3:0] != z) && ({1'b0, l[3:0]} < dz);
    endfunction

    always_comb
    begin
        plane          = ADDR_W'(cfg.dim_x * cfg.dim_y);
        cmd.action     = action_t'(action);
        cmd.own_addr   = addr_of(cell_x, cell_y, cell_z, cfg.dim_x, plane);
        cmd.paddr_a    = addr_of(cell_x, cell_y, layer_a[3:0], cfg.dim_x, plane);
        cmd.paddr_b    = addr_of(cell_x, cell_y, layer_b[3:0], cfg.dim_x, plane);
        cmd.pvalid[0]  = partner_ok(layer_a, cell_z, cfg.dim_z);
        cmd.pvalid[1]  = partner_ok(layer_b, cell_z, cfg.dim_z);
        cmd.mag_x      = mag_x;
        cmd.mag_y      = mag_y;
        cmd.mag_z      = mag_z;
        cmd.sat        = sat_mag;
        cmd.coupling   = coupling;
    end

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/iexf_div.sv =====
module iexf_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [47:0]  dividend,
    input  logic [23:0]         divisor,
    output logic                busy,
    output logic                done,
    output logic signed [48:0]  quotient
);
    import iexf_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [23:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [23:0] div_reg, div_next;
    logic [24:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[47]};
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[47];
            quo_next  = dividend[47] ? 48'(-dividend) : 48'(dividend);
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = 6'd47;
        end
        else if (busy_reg)
        begin
            // Restoring division, one quotient bit per cycle.
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = 24'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial[23:0];
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// ===== sv/iexf_back.sv =====
module iexf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  iexf_pkg::cfg_t      cfg,
    input  iexf_pkg::cmd_t      head,
    input  logic                head_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  field_x,
    output logic signed [31:0]  field_y,
    output logic signed [31:0]  field_z,
    output logic signed [63:0]  energy
);
    import iexf_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE   = 18'b000000000000000001,
        S_OWN    = 18'b000000000000000010,
        S_PISS   = 18'b000000000000000100,
        S_PWAIT  = 18'b000000000000001000,
        S_PDIV   = 18'b000000000000010000,
        S_PDWAIT = 18'b000000000000100000,
        S_TMUL   = 18'b000000000001000000,
        S_TSAT   = 18'b000000000010000000,
        S_UMUL   = 18'b000000000100000000,
        S_USAT   = 18'b000000001000000000,
        S_HDIV   = 18'b000000010000000000,
        S_HWAIT  = 18'b000000100000000000,
        S_EMUL   = 18'b000001000000000000,
        S_ESUM   = 18'b000010000000000000,
        S_EACC   = 18'b000100000000000000,
        S_MLO    = 18'b001000000000000000,
        S_MHI    = 18'b010000000000000000,
        S_FIN    = 18'b100000000000000000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cur_reg, cur_next;
    logic               pidx_reg, pidx_next;
    logic [1:0]         comp_reg, comp_next;
    logic signed [23:0] own_m_reg [3];
    logic signed [23:0] own_m_next [3];
    logic [23:0]        own_sat_reg, own_sat_next;
    logic signed [23:0] pm_reg [3];
    logic signed [23:0] pm_next [3];
    logic [23:0]        psat_reg, psat_next;
    logic signed [40:0] ratio_reg [3];
    logic signed [40:0] ratio_next [3];
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] u_reg, u_next;
    logic signed [31:0] h_reg [3];
    logic signed [31:0] h_next [3];
    logic signed [41:0] term_reg, term_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [63:0]        mlo_reg, mlo_next;
    logic [63:0]        mhi_reg, mhi_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] fx_reg, fx_next, fy_reg, fy_next, fz_reg, fz_next;
    logic signed [63:0] en_reg, en_next;

    logic [95:0]        mem [GRID_CELLS];
    logic [95:0]        rdata_reg;
    logic [ADDR_W-1:0]  raddr;
    logic               mem_we;

    logic               div_start, div_busy, div_done;
    logic signed [47:0] div_dividend;
    logic [23:0]        div_divisor;
    logic signed [48:0] div_q;

    logic signed [31:0] s_cur;
    logic signed [47:0] tr;
    logic signed [64:0] acc_sum;
    logic [63:0]        ua;
    logic [31:0]        ub;
    logic [63:0]        tmag;
    logic               eneg;

    iexf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[head.own_addr] <= {head.mag_x, head.mag_y, head.mag_z, head.sat};
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        raddr        = head.own_addr;
        if (state_reg == S_PISS)
            raddr = pidx_reg ? cur_reg.paddr_b : cur_reg.paddr_a;
        div_dividend = (state_reg == S_HDIV) ? {u_reg, 16'h0000}
                                             : {{8{pm_reg[comp_reg][23]}}, pm_reg[comp_reg], 16'h0000};
        div_divisor  = (state_reg == S_HDIV) ? own_sat_reg : psat_reg;
        s_cur        = sat32(64'(ratio_reg[comp_reg]));
        tr           = trunc16(prod_reg);
        acc_sum      = {acc_reg[63], acc_reg} + 65'(term_reg);
        ua           = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
        ub           = cfg.energy_scale[31] ? 32'(-cfg.energy_scale) : 32'(cfg.energy_scale);
        eneg         = acc_reg[63] ^ cfg.energy_scale[31];
        tmag         = (mhi_reg >= 64'h0000_8000_0000_0000) ? '1
                                                           : (mhi_reg << 16) + (mlo_reg >> 16);
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        pidx_next      = pidx_reg;
        comp_next      = comp_reg;
        own_m_next     = own_m_reg;
        own_sat_next   = own_sat_reg;
        pm_next        = pm_reg;
        psat_next      = psat_reg;
        ratio_next     = ratio_reg;
        prod_next      = prod_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        h_next         = h_reg;
        term_next      = term_reg;
        acc_next       = acc_reg;
        mlo_next       = mlo_reg;
        mhi_next       = mhi_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        fz_next        = fz_reg;
        en_next        = en_reg;
        out_valid_next = out_valid_reg && out_stall;
        pop            = 1'b0;
        mem_we         = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    unique case (head.action)
                        ACT_LOAD:  mem_we = 1'b1;
                        ACT_EVAL:  state_next = S_OWN;
                        ACT_CLEAR: acc_next = '0;
                        default:   ;
                    endcase
                end
            end
            S_OWN:
            begin
                own_m_next[0] = rdata_reg[95:72];
                own_m_next[1] = rdata_reg[71:48];
                own_m_next[2] = rdata_reg[47:24];
                own_sat_next  = rdata_reg[23:0];
                for (int i = 0; i < 3; i++)
                begin
                    ratio_next[i] = '0;
                    h_next[i]     = '0;
                end
                term_next = '0;
                pidx_next = 1'b0;
                // An empty own cell reports a zero field and leaves the energy alone.
                state_next = (rdata_reg[23:0] == 24'd0) ? S_MLO : S_PISS;
            end
            S_PISS:
            begin
                if (cur_reg.pvalid[pidx_reg])
                    state_next = S_PWAIT;
                else if (pidx_reg)
                begin
                    comp_next  = 2'd0;
                    state_next = S_TMUL;
                end
                else
                    pidx_next = 1'b1;
            end
            S_PWAIT:
            begin
                pm_next[0] = rdata_reg[95:72];
                pm_next[1] = rdata_reg[71:48];
                pm_next[2] = rdata_reg[47:24];
                psat_next  = rdata_reg[23:0];
                comp_next  = 2'd0;
                if (rdata_reg[23:0] != 24'd0)
                    state_next = S_PDIV;
                else if (pidx_reg)
                    state_next = S_TMUL;
                else
                begin
                    pidx_next  = 1'b1;
                    state_next = S_PISS;
                end
            end
            S_PDIV:
            begin
                div_start  = 1'b1;
                state_next = S_PDWAIT;
            end
            S_PDWAIT:
            begin
                if (div_done)
                begin
                    ratio_next[comp_reg] = ratio_reg[comp_reg] + div_q[40:0];
                    if (comp_reg != 2'd2)
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_PDIV;
                    end
                    else if (pidx_reg)
                    begin
                        comp_next  = 2'd0;
                        state_next = S_TMUL;
                    end
                    else
                    begin
                        pidx_next  = 1'b1;
                        state_next = S_PISS;
                    end
                end
            end
            S_TMUL:
            begin
                prod_next  = cur_reg.coupling * s_cur;
                state_next = S_TSAT;
            end
            S_TSAT:
            begin
                t_next     = sat32(64'(tr));
                state_next = S_UMUL;
            end
            S_UMUL:
            begin
                prod_next  = t_reg * cfg.field_scale;
                state_next = S_USAT;
            end
            S_USAT:
            begin
                u_next     = sat32(64'(tr));
                state_next = S_HDIV;
            end
            S_HDIV:
            begin
                div_start  = 1'b1;
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (div_done)
                begin
                    h_next[comp_reg] = sat32(64'(div_q));
                    state_next       = S_EMUL;
                end
            end
            S_EMUL:
            begin
                prod_next  = own_m_reg[comp_reg] * h_reg[comp_reg];
                state_next = S_ESUM;
            end
            S_ESUM:
            begin
                term_next = term_reg + tr[41:0];
                if (comp_reg == 2'd2)
                    state_next = S_EACC;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_TMUL;
                end
            end
            S_EACC:
            begin
                if (acc_sum[64] != acc_sum[63])
                    acc_next = acc_sum[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
                else
                    acc_next = acc_sum[63:0];
                state_next = S_MLO;
            end
            S_MLO:
            begin
                mlo_next   = ua[31:0] * ub;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                mhi_next   = ua[63:32] * ub;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fx_next = h_reg[0];
                    fy_next = h_reg[1];
                    fz_next = h_reg[2];
                    if (eneg)
                        en_next = tmag[63] ? 64'sh8000000000000000 : -$signed(tmag);
                    else
                        en_next = tmag[63] ? 64'sh7FFFFFFFFFFFFFFF : $signed(tmag);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        pidx_reg    <= pidx_next;
        comp_reg    <= comp_next;
        own_m_reg   <= own_m_next;
        own_sat_reg <= own_sat_next;
        pm_reg      <= pm_next;
        psat_reg    <= psat_next;
        ratio_reg   <= ratio_next;
        prod_reg    <= prod_next;
        t_reg       <= t_next;
        u_reg       <= u_next;
        h_reg       <= h_next;
        term_reg    <= term_next;
        mlo_reg     <= mlo_next;
        mhi_reg     <= mhi_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        fz_reg      <= fz_next;
        en_reg      <= en_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign field_x   = fx_reg;
    assign field_y   = fy_reg;
    assign field_z   = fz_reg;
    assign energy    = en_reg;

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == S_IDLE)
        else $error("queue popped outside idle");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside final step");

endmodule

// ===== sv/interlayer_exchange_field_top.sv =====
// Interlayer exchange field unit.
// Input channel (in_valid/in_stall) carries one transaction per item: load a
// cell into the grid store, evaluate a cell, clear the running energy, or no-op.
// Output channel (out_valid/out_stall) carries one result per evaluate item:
// the three field components and the scaled running energy.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
// A two-entry queue sits between the accepting front and the executing back,
// so up to two further items are taken while one is being worked on.
// Load and clear items are completed by the back part in its idle state. An
// evaluate item reads its own cell and each partner layer that is used; the
// shared bit-serial divider does three divisions per partner with nonzero
// saturation and three by the own saturation. An empty own cell skips the
// partner reads and the divisions.
// Reset clears the queue, the running energy and the output valid, and loads
// the default register values; the grid store is not cleared.
// While the receiver stalls, the result is held in the output register and the
// back part waits before presenting the next one; the queue then fills and
// in_stall rises.
module interlayer_exchange_field_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [5:0]          cell_x,
    input  logic [5:0]          cell_y,
    input  logic [3:0]          cell_z,
    input  logic signed [23:0]  mag_x,
    input  logic signed [23:0]  mag_y,
    input  logic signed [23:0]  mag_z,
    input  logic [23:0]         sat_mag,
    input  logic signed [4:0]   layer_a,
    input  logic signed [4:0]   layer_b,
    input  logic signed [31:0]  coupling,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  field_x,
    output logic signed [31:0]  field_y,
    output logic signed [31:0]  field_z,
    output logic signed [63:0]  energy
);
    import iexf_pkg::*;

    cfg_t cfg_reg;
    cmd_t head;
    logic head_valid;
    logic pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_x        <= 7'd1;
            cfg_reg.dim_y        <= 7'd1;
            cfg_reg.dim_z        <= 5'd1;
            cfg_reg.field_scale  <= 32'sd65536;
            cfg_reg.energy_scale <= -32'sd65536;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DIM_X:        cfg_reg.dim_x        <= cfg_data[6:0];
                REG_DIM_Y:        cfg_reg.dim_y        <= cfg_data[6:0];
                REG_DIM_Z:        cfg_reg.dim_z        <= cfg_data[4:0];
                REG_FIELD_SCALE:  cfg_reg.field_scale  <= cfg_data;
                REG_ENERGY_SCALE: cfg_reg.energy_scale <= cfg_data;
                default:          ;
            endcase
        end
    end

    iexf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_z     (cell_z),
        .mag_x      (mag_x),
        .mag_y      (mag_y),
        .mag_z      (mag_z),
        .sat_mag    (sat_mag),
        .layer_a    (layer_a),
        .layer_b    (layer_b),
        .coupling   (coupling),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    iexf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .field_x    (field_x),
        .field_y    (field_y),
        .field_z    (field_z),
        .energy     (energy)
    );

endmodule
